@@ hdl/pt_pkg.sv @@
// ----------------------------------------------------------------------------
// pt_pkg
// Shared types and constants for the permission table.
// ----------------------------------------------------------------------------
`default_nettype none

package pt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        REQ_INIT       = 4'd0,
        REQ_CLEAR      = 4'd1,
        REQ_ADD        = 4'd2,
        REQ_REMOVE     = 4'd3,
        REQ_CHECK      = 4'd4,
        REQ_SET_PERM   = 4'd5,
        REQ_OR_PERM    = 4'd6,
        REQ_CLEAR_BITS = 4'd7,
        REQ_SET_QUOTA  = 4'd8,
        REQ_READ       = 4'd9
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DENIED    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_INIT  = 3'd5
    } t_status;

    typedef logic [IDX_W-1:0] t_idx;

endpackage : pt_pkg

`default_nettype wire

@@ hdl/permission_table_top.sv @@
// ----------------------------------------------------------------------------
// permission_table_top
// Identifier-keyed table of permission masks and quotas, searched one slot
// per cycle by a single shared comparator.
//
//   channel   handshake          fields                                dir
//   request   i_valid o_ready    i_req_type i_module_id i_value        in
//   result    o_valid i_ready    o_status o_perm_out o_quota_out       out
//
// init, clear, unknown codes and requests on an uninitialised table are
// answered from S_EXEC; table requests go on from S_EXEC to S_SCAN, which
// reads slots in order until a hit or slot TABLE_ENTRIES - 1 (a miss, or an
// add with no match); o_ready rises with o_valid.
// reset clears the ready flag and every slot-used bit; no clearing pass.
// a result waiting on i_ready holds the next request in its first step.
// ----------------------------------------------------------------------------
`default_nettype none

module permission_table_top
    import pt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_req_type,
    input  wire logic [31:0] i_module_id,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_perm_out,
    output logic [31:0]      o_quota_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    localparam t_idx LAST_IDX = t_idx'(TABLE_ENTRIES - 1);

    t_state                   r_state, n_state;
    t_req                     r_req;
    logic [31:0]              r_id, r_val;
    logic                     r_table_ready, n_table_ready;
    logic [TABLE_ENTRIES-1:0] r_used, n_used;
    t_idx                     r_idx, n_idx;
    logic                     r_issue, n_issue;
    logic                     r_rd_vld, n_rd_vld;
    t_idx                     r_rd_idx, n_rd_idx;
    logic [31:0]              r_rd_id, r_rd_perm, r_rd_quota;
    logic                     r_free_found, n_free_found;
    t_idx                     r_free_idx, n_free_idx;
    logic                     r_o_valid, n_o_valid;
    t_status                  r_o_status, n_o_status;
    logic [31:0]              r_o_perm, n_o_perm;
    logic [31:0]              r_o_quota, n_o_quota;

    logic [31:0] m_id    [TABLE_ENTRIES];
    logic [31:0] m_perm  [TABLE_ENTRIES];
    logic [31:0] m_quota [TABLE_ENTRIES];

    logic        rd_en;
    logic        we_id, we_perm, we_quota;
    t_idx        w_idx;
    logic [31:0] w_perm, w_quota;

    logic        accept, can_out, hit, last, fin, adv, free_now, free_any;
    t_idx        free_sel;

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_perm_out  = r_o_perm;
    assign o_quota_out = r_o_quota;

    assign can_out  = !r_o_valid || i_ready;
    assign hit      = r_rd_vld && r_used[r_rd_idx] && (r_rd_id == r_id);
    assign last     = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign fin      = (r_state == S_SCAN) && (hit || last);
    assign adv      = !fin || can_out;
    assign free_now = r_rd_vld && !r_used[r_rd_idx];
    assign free_any = r_free_found || free_now;
    assign free_sel = r_free_found ? r_free_idx : r_rd_idx;

    always_comb begin
        n_state       = r_state;
        n_table_ready = r_table_ready;
        n_used        = r_used;
        n_idx         = r_idx;
        n_issue       = r_issue;
        n_rd_vld      = r_rd_vld;
        n_rd_idx      = r_rd_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_o_valid     = r_o_valid && !i_ready;
        n_o_status    = r_o_status;
        n_o_perm      = r_o_perm;
        n_o_quota     = r_o_quota;
        rd_en         = 1'b0;
        we_id         = 1'b0;
        we_perm       = 1'b0;
        we_quota      = 1'b0;
        w_idx         = r_rd_idx;
        w_perm        = r_val;
        w_quota       = r_val;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_out) begin
                    n_o_status = ST_OK;
                    n_o_perm   = '0;
                    n_o_quota  = '0;
                    n_o_valid  = 1'b1;
                    n_state    = S_IDLE;
                    case (r_req)
                        REQ_INIT: begin
                            if (!r_table_ready) begin
                                n_used        = '0;
                                n_table_ready = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_used        = '0;
                            n_table_ready = 1'b0;
                        end
                        REQ_ADD, REQ_REMOVE, REQ_CHECK, REQ_SET_PERM, REQ_OR_PERM,
                        REQ_CLEAR_BITS, REQ_SET_QUOTA, REQ_READ: begin
                            if (!r_table_ready) begin
                                n_o_status = (r_req == REQ_ADD || r_req == REQ_REMOVE)
                                             ? ST_NOT_INIT : ST_NOT_FOUND;
                            end else begin
                                n_o_valid    = r_o_valid && !i_ready;
                                n_state      = S_SCAN;
                                n_idx        = '0;
                                n_issue      = 1'b1;
                                n_rd_vld     = 1'b0;
                                n_free_found = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (adv) begin
                    rd_en    = r_issue;
                    n_rd_vld = r_issue;
                    n_rd_idx = r_idx;
                    if (r_issue) begin
                        n_idx   = r_idx + t_idx'(1);
                        n_issue = (r_idx != LAST_IDX);
                    end
                    if (free_now && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                end
                if (fin && can_out) begin
                    n_state    = S_IDLE;
                    n_rd_vld   = 1'b0;
                    n_issue    = 1'b0;
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_perm   = '0;
                    n_o_quota  = '0;
                    if (hit) begin
                        case (r_req)
                            REQ_ADD:        n_o_status = ST_EXISTS;
                            REQ_REMOVE:     n_used[r_rd_idx] = 1'b0;
                            REQ_CHECK: begin
                                n_o_status = ((r_rd_perm & r_val) == r_val)
                                             ? ST_OK : ST_DENIED;
                            end
                            REQ_SET_PERM: begin
                                we_perm = 1'b1;
                                w_perm  = r_val;
                            end
                            REQ_OR_PERM: begin
                                we_perm = 1'b1;
                                w_perm  = r_rd_perm | r_val;
                            end
                            REQ_CLEAR_BITS: begin
                                we_perm = 1'b1;
                                w_perm  = r_rd_perm & ~r_val;
                            end
                            REQ_SET_QUOTA: begin
                                we_quota = 1'b1;
                                w_quota  = r_val;
                            end
                            REQ_READ: begin
                                n_o_perm  = r_rd_perm;
                                n_o_quota = r_rd_quota;
                            end
                            default: begin
                            end
                        endcase
                    end else if (r_req == REQ_ADD) begin
                        if (free_any) begin
                            we_id            = 1'b1;
                            we_perm          = 1'b1;
                            we_quota         = 1'b1;
                            w_idx            = free_sel;
                            w_perm           = r_val;
                            w_quota          = '0;
                            n_used[free_sel] = 1'b1;
                        end else begin
                            n_o_status = ST_FULL;
                        end
                    end else begin
                        n_o_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_ready <= 1'b0;
            r_used        <= '0;
            r_issue       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_free_found  <= 1'b0;
            r_o_valid     <= 1'b0;
            r_o_status    <= ST_OK;
            r_o_perm      <= '0;
            r_o_quota     <= '0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_used        <= n_used;
            r_issue       <= n_issue;
            r_rd_vld      <= n_rd_vld;
            r_free_found  <= n_free_found;
            r_o_valid     <= n_o_valid;
            r_o_status    <= n_o_status;
            r_o_perm      <= n_o_perm;
            r_o_quota     <= n_o_quota;
        end
    end

    // request capture and search pointers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_req_type);
            r_id  <= i_module_id;
            r_val <= i_value;
        end
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_free_idx <= n_free_idx;
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id    <= m_id[r_idx];
            r_rd_perm  <= m_perm[r_idx];
            r_rd_quota <= m_quota[r_idx];
        end
        if (we_id) begin
            m_id[w_idx] <= r_id;
        end
        if (we_perm) begin
            m_perm[w_idx] <= w_perm;
        end
        if (we_quota) begin
            m_quota[w_idx] <= w_quota;
        end
    end

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("request taken while busy");

    a_uninit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_table_ready |-> (r_used == '0))
        else $error("slot in use on uninitialised table");

    a_data_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_perm_out == '0 && o_quota_out == '0))
        else $error("data on failed request");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("slot read outside search");

    a_used_stable_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !fin) |=> $stable(r_used))
        else $error("slot use changed mid-search");

endmodule : permission_table_top

`default_nettype wire
